[design/hsi_pkg.sv]
package hsi_pkg;

  // Table geometry
  localparam int SLOTS     = 64;
  localparam int SLOT_W    = $clog2(SLOTS);
  localparam int KEY_BYTES = 8;
  localparam int KEY_W     = 64;
  localparam int LEN_W     = 4;
  localparam int CNT_W     = 6;

  // FNV-1a 32-bit
  localparam logic [31:0] FNV_BASIS = 32'd2166136261;
  localparam logic [31:0] FNV_PRIME = 32'd16777619;

  localparam logic [CNT_W-1:0] MAX_ENTRIES_RST = CNT_W'(48);

  typedef enum logic [1:0] {
    ST_NEW     = 2'd0,
    ST_PRESENT = 2'd1,
    ST_FULL    = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_HASH,
    S_PROBE,
    S_CMP
  } fsm_t;

  typedef struct packed {
    logic [KEY_W-1:0] key_bytes;
    logic [LEN_W-1:0] key_length;
  } in_t;

  typedef struct packed {
    status_t           status;
    logic [SLOT_W-1:0] slot_index;
    logic [CNT_W-1:0]  entry_count;
  } out_t;

endpackage

[design/hash_set_insert_linear_probe.sv]
// Hash set insert, open addressing with linear probing, 64 slots.
//
// Input: a request beat is taken at a clock edge with start high and busy
// low. in_data carries up to eight key bytes (first byte in bits 7:0) and a
// length; lengths above eight count as eight, bytes past the length are
// ignored. Result: one beat per request on out_data, marked by out_valid
// for exactly one cycle; the receiver cannot hold it off. Status tells new,
// already present or refused, with the slot and the entry count afterwards.
// cfg_we/cfg_wdata write max_entries (reset value 48); write only when idle.
//
// Timing: the hash folds in one key byte per cycle (one 32x32 multiply per
// byte), then a last hash step picks the start slot; every probed slot then
// passes S_PROBE (synchronous slot memory read) and S_CMP (compare and
// write-back). Busy is low again in the cycle the result shows, so a new
// request may start there.
//
// Reset clears all slot-used bits, the entry count and max_entries to 48;
// the key store itself is not cleared, a clear used bit hides its contents.
module hash_set_insert_linear_probe (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  hsi_pkg::in_t        in_data,
  output logic                out_valid,
  output hsi_pkg::out_t       out_data,
  input  logic                cfg_we,
  input  logic [hsi_pkg::CNT_W-1:0] cfg_wdata
);
  import hsi_pkg::*;

  localparam int ENT_W = KEY_W + LEN_W;

  fsm_t              state_r, state_nxt;
  logic [31:0]       hash_r, hash_nxt;
  logic [KEY_W-1:0]  key_r, key_nxt;
  logic [LEN_W-1:0]  len_r, len_nxt;
  logic [LEN_W-1:0]  bcnt_r, bcnt_nxt;
  logic [SLOT_W-1:0] idx_r, idx_nxt;
  logic [SLOT_W-1:0] pcnt_r, pcnt_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [CNT_W-1:0]  max_r;
  logic [SLOTS-1:0]  used_r, used_nxt;
  logic              out_valid_r, out_valid_nxt;
  out_t              out_r, out_nxt;

  // slot store: key and length per slot
  logic [ENT_W-1:0]  slot_mem [SLOTS];
  logic [ENT_W-1:0]  rd_r;
  logic              mem_we;

  logic [LEN_W-1:0]  len_eff;
  logic [KEY_W-1:0]  key_masked;
  logic [7:0]        cur_byte;
  logic              hit;

  // clamp length and clear ignored bytes
  always_comb begin
    len_eff = (in_data.key_length > LEN_W'(KEY_BYTES)) ? LEN_W'(KEY_BYTES)
                                                       : in_data.key_length;
    for (int i = 0; i < KEY_W / 8; i++) begin
      key_masked[8*i +: 8] = (i < int'(len_eff)) ? in_data.key_bytes[8*i +: 8] : 8'd0;
    end
  end

  assign cur_byte = 8'(key_r >> {bcnt_r, 3'b000});
  assign hit      = (rd_r[LEN_W-1:0] == len_r) && (rd_r[ENT_W-1:LEN_W] == key_r);

  // next state and datapath
  always_comb begin
    state_nxt     = state_r;
    hash_nxt      = hash_r;
    key_nxt       = key_r;
    len_nxt       = len_r;
    bcnt_nxt      = bcnt_r;
    idx_nxt       = idx_r;
    pcnt_nxt      = pcnt_r;
    count_nxt     = count_r;
    used_nxt      = used_r;
    out_valid_nxt = 1'b0;
    out_nxt       = out_r;
    mem_we        = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          key_nxt   = key_masked;
          len_nxt   = len_eff;
          hash_nxt  = FNV_BASIS;
          bcnt_nxt  = '0;
          state_nxt = S_HASH;
        end
      end
      S_HASH: begin
        if (bcnt_r == len_r) begin
          idx_nxt   = hash_r[SLOT_W-1:0];
          pcnt_nxt  = '0;
          state_nxt = S_PROBE;
        end else begin
          hash_nxt = 32'((hash_r ^ {24'd0, cur_byte}) * FNV_PRIME);
          bcnt_nxt = bcnt_r + 1'b1;
        end
      end
      // memory read of idx_r in flight
      S_PROBE: state_nxt = S_CMP;
      S_CMP: begin
        state_nxt = S_IDLE;
        out_valid_nxt = 1'b1;
        out_nxt.slot_index = '0;
        out_nxt.status     = ST_FULL;
        if (!used_r[idx_r]) begin
          if ({1'b0, count_r} + 1'b1 <= {1'b0, max_r}) begin
            mem_we             = 1'b1;
            used_nxt[idx_r]    = 1'b1;
            count_nxt          = count_r + 1'b1;
            out_nxt.status     = ST_NEW;
            out_nxt.slot_index = idx_r;
          end
        end else if (hit) begin
          out_nxt.status     = ST_PRESENT;
          out_nxt.slot_index = idx_r;
        end else if (pcnt_r != SLOT_W'(SLOTS - 1)) begin
          // keep walking
          out_valid_nxt = 1'b0;
          out_nxt       = out_r;
          idx_nxt       = idx_r + 1'b1;
          pcnt_nxt      = pcnt_r + 1'b1;
          state_nxt     = S_PROBE;
        end
        out_nxt.entry_count = count_nxt;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      used_r      <= '0;
      out_valid_r <= 1'b0;
      max_r       <= MAX_ENTRIES_RST;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      used_r      <= used_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        max_r <= cfg_wdata;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    hash_r <= hash_nxt;
    key_r  <= key_nxt;
    len_r  <= len_nxt;
    bcnt_r <= bcnt_nxt;
    idx_r  <= idx_nxt;
    pcnt_r <= pcnt_nxt;
    out_r  <= out_nxt;
  end

  // slot memory, one write and one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      slot_mem[idx_r] <= {key_r, len_r};
    end
    rd_r <= slot_mem[idx_r];
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

[design/hsi_checker.sv]
module hsi_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                start,
  input logic                busy,
  input logic                out_valid,
  input hsi_pkg::out_t       out_data
);
  import hsi_pkg::*;

  // an accepted request keeps the block busy next cycle
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("request accepted but busy not raised");

  // result strobe is a single-cycle pulse
  a_strobe_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe held longer than one cycle");

  // block is free again when its result shows
  a_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result shown while still busy");

  // refused requests report slot zero
  a_full_slot: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.status == ST_FULL) |-> (out_data.slot_index == '0))
    else $error("refused request with nonzero slot");

  // a fresh insert leaves at least one entry
  a_new_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.status == ST_NEW) |-> (out_data.entry_count != '0))
    else $error("new key reported with zero count");

endmodule

bind hash_set_insert_linear_probe hsi_checker u_hsi_checker (.*);
